/* design/assert_macros.svh */
// Assertion macros shared by the encoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Concurrent assertion on the local clk / arst_n.
`define ASSERT_DEF(lbl, prop, msg) `ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

/* design/rne_pkg.sv */
// Package: types, codes and numeral tables for the Roman numeral encoder.
`default_nettype none
package rne_pkg;

	localparam int unsigned NUM_W       = 12;
	localparam int unsigned SYM_W       = 8;
	localparam int unsigned PAIR_COUNT  = 13;
	localparam int unsigned PAIR_IDX_W  = 4;
	localparam int unsigned ZERO_LEN    = 5;
	localparam int unsigned ZERO_IDX_W  = 3;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [NUM_W-1:0] LIMIT_VALUE = 12'd4000;
	localparam logic [SYM_W-1:0] SYM_NONE    = 8'h00;

	typedef enum logic [1:0] {
		KIND_NORMAL = 2'd0,
		KIND_ZERO   = 2'd1,
		KIND_OOR    = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t            kind;
		logic [NUM_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	localparam logic [NUM_W-1:0] PAIR_VALUE [PAIR_COUNT] = '{
		12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
		12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
	};
	// M C D C C X L X X I V I I
	localparam logic [SYM_W-1:0] PAIR_FIRST [PAIR_COUNT] = '{
		8'h4D, 8'h43, 8'h44, 8'h43, 8'h43, 8'h58, 8'h4C,
		8'h58, 8'h58, 8'h49, 8'h56, 8'h49, 8'h49
	};
	// second letter of subtractive pairs, zero for single letters
	localparam logic [SYM_W-1:0] PAIR_SECOND [PAIR_COUNT] = '{
		8'h00, 8'h4D, 8'h00, 8'h44, 8'h00, 8'h43, 8'h00,
		8'h4C, 8'h00, 8'h58, 8'h00, 8'h56, 8'h00
	};
	// "nulla"
	localparam logic [SYM_W-1:0] ZERO_WORD [ZERO_LEN] = '{
		8'h6E, 8'h75, 8'h6C, 8'h6C, 8'h61
	};

	// First pair whose value fits into v; the last pair (I) when none does.
	function automatic logic [PAIR_IDX_W-1:0] pair_index(input logic [NUM_W-1:0] v);
		logic [PAIR_IDX_W-1:0] idx;
		logic                  found;
		idx   = PAIR_IDX_W'(PAIR_COUNT - 1);
		found = 1'b0;
		for (int i = 0; i < PAIR_COUNT; i++) begin
			if (!found && v >= PAIR_VALUE[i]) begin
				idx   = PAIR_IDX_W'(i);
				found = 1'b1;
			end
		end
		return idx;
	endfunction

endpackage
`default_nettype wire

/* design/rne_front.sv */
// Front end: accepts numbers and classifies them into queue items.
`default_nettype none
module rne_front (
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	input  wire logic [15:0]               s_tdata,
	input  wire rne_pkg::q_stat_t          q_stat,
	output logic                           push,
	output rne_pkg::item_t                 push_item
);

	logic [rne_pkg::NUM_W-1:0] number;

	assign number   = s_tdata[rne_pkg::NUM_W-1:0];
	assign s_tready = !q_stat.full;
	assign push     = s_tvalid && !q_stat.full;

	always_comb begin
		push_item.value = number;
		priority if (number >= rne_pkg::LIMIT_VALUE) begin
			push_item.kind = rne_pkg::KIND_OOR;
		end else if (number == '0) begin
			push_item.kind = rne_pkg::KIND_ZERO;
		end else begin
			push_item.kind = rne_pkg::KIND_NORMAL;
		end
	end

endmodule
`default_nettype wire

/* design/rne_fifo.sv */
// Short item queue between the front end and the character generator.
`default_nettype none
`include "assert_macros.svh"
module rne_fifo #(
	parameter int unsigned DEPTH = rne_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire rne_pkg::item_t   push_item,
	input  wire logic             pop,
	output rne_pkg::item_t        head,
	output rne_pkg::q_stat_t      stat
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	rne_pkg::item_t  entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ASSERT_DEF(a_count_bound, count_q <= CW'(DEPTH), "queue count above depth")
	`ASSERT_DEF(a_no_overflow, !(push && stat.full), "push into a full queue")

endmodule
`default_nettype wire

/* design/rne_back.sv */
// Back end: turns one queued number into a run of numeral characters.
`default_nettype none
`include "assert_macros.svh"
module rne_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire rne_pkg::item_t              head,
	input  wire rne_pkg::q_stat_t            q_stat,
	output logic                             pop,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [rne_pkg::SYM_W-1:0]        m_tdata,
	output logic                             m_tlast,
	output logic                             m_tuser
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t                          state_q;
	rne_pkg::kind_t                  kind_q;
	logic [rne_pkg::NUM_W-1:0]       rem_q;
	logic [rne_pkg::PAIR_IDX_W-1:0]  pos_q;
	logic                            pend_q;
	logic [rne_pkg::ZERO_IDX_W-1:0]  zidx_q;

	logic                            out_valid_q;
	logic [rne_pkg::SYM_W-1:0]       sym_q;
	logic                            last_q;
	logic                            oor_q;

	logic                            adv;
	logic                            emit;
	logic [rne_pkg::PAIR_IDX_W-1:0]  idx;
	logic [rne_pkg::NUM_W-1:0]       rem_nxt;
	logic [rne_pkg::SYM_W-1:0]       sym_c;
	logic                            last_c;
	logic                            oor_c;
	logic                            pend_nxt;

	assign adv  = !out_valid_q || m_tready;
	assign emit = (state_q == ST_RUN) && adv;
	assign pop  = (state_q == ST_IDLE) && !q_stat.empty;

	assign idx  = rne_pkg::pair_index(rem_q);

	always_comb begin
		rem_nxt  = rem_q;
		pend_nxt = 1'b0;
		sym_c    = rne_pkg::SYM_NONE;
		last_c   = 1'b1;
		oor_c    = 1'b0;
		unique case (kind_q)
			rne_pkg::KIND_OOR: begin
				oor_c = 1'b1;
			end
			rne_pkg::KIND_ZERO: begin
				sym_c  = rne_pkg::ZERO_WORD[zidx_q];
				last_c = (zidx_q == rne_pkg::ZERO_IDX_W'(rne_pkg::ZERO_LEN - 1));
			end
			rne_pkg::KIND_NORMAL: begin
				if (pend_q) begin
					sym_c  = rne_pkg::PAIR_SECOND[pos_q];
					last_c = (rem_q == '0);
				end else begin
					rem_nxt  = rem_q - rne_pkg::PAIR_VALUE[idx];
					sym_c    = rne_pkg::PAIR_FIRST[idx];
					pend_nxt = (rne_pkg::PAIR_SECOND[idx] != rne_pkg::SYM_NONE);
					last_c   = (rem_nxt == '0) && !pend_nxt;
				end
			end
			default: begin
				oor_c = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= rne_pkg::KIND_NORMAL;
			rem_q       <= '0;
			pos_q       <= '0;
			pend_q      <= 1'b0;
			zidx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_RUN;
						kind_q  <= head.kind;
						rem_q   <= head.value;
						pos_q   <= '0;
						pend_q  <= 1'b0;
						zidx_q  <= '0;
					end
				end
				ST_RUN: begin
					if (emit) begin
						rem_q  <= rem_nxt;
						pend_q <= pend_nxt;
						zidx_q <= zidx_q + 1'b1;
						if (!pend_q) begin
							pos_q <= idx;
						end
						if (last_c) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			sym_q  <= sym_c;
			last_q <= last_c;
			oor_q  <= oor_c;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = sym_q;
	assign m_tlast  = last_q;
	assign m_tuser  = oor_q;

	`ASSERT_DEF(a_oor_is_last, (out_valid_q && oor_q) |-> last_q,
		"error item not marked last")
	`ASSERT_DEF(a_last_ends_run, (emit && last_c) |=> (state_q == ST_IDLE),
		"run continues after last character")
	`ASSERT_DEF(a_zero_index, zidx_q <= rne_pkg::ZERO_IDX_W'(rne_pkg::ZERO_LEN)
		|| kind_q != rne_pkg::KIND_ZERO, "zero word index out of range")

endmodule
`default_nettype wire

/* design/roman_numeral_encoder.sv */
// Top level: Roman numeral encoder, number in, ASCII numeral characters out.
// A number accepted into the queue is loaded into the character generator,
// which registers its first character into the output register for m_tdata.
// The generator gives one character per cycle while m_tready allows and
// takes a new number from the queue only in ST_IDLE, after the last character.
// Reset (arst_n low, asynchronous): queue emptied, generator idle, no output.
`default_nettype none
module roman_numeral_encoder #(
	parameter int unsigned QUEUE_DEPTH = rne_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input items
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [11:0] number, [15:12] zero
	// result items
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [7:0] symbol (ASCII, zero on error)
	output logic             m_tlast,   // final_char
	output logic             m_tuser    // out_of_range
);

	// front end -> queue
	logic              push;
	rne_pkg::item_t    push_item;
	// queue -> back end
	rne_pkg::item_t    head;
	rne_pkg::q_stat_t  q_stat;
	logic              pop;

	// Classifies each number as normal, zero or out of range; stalls only
	// when the queue is full.
	rne_front u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.q_stat    (q_stat),
		.push      (push),
		.push_item (push_item)
	);

	// Decouples intake from character output so a new number can be taken
	// while the previous numeral is still streaming out.
	rne_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	// Greedy conversion, one character per cycle into an output register while
	// m_tready allows; subtractive pairs give their two letters one after the other.
	rne_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_stat   (q_stat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire
